>>> src/tpec_pkg.sv
// types, constants and codes shared by the tcp passive echo connection engine
package tpec_pkg;

    localparam int CONNECTIONS = 8;
    localparam int SLOT_W      = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CONNECTIONS - 1);

    localparam int PADDR_W = 3;
    localparam logic [31:0] ISS_RESET = 32'd5658;

    typedef enum logic [0:0] {
        REG_INITIAL_SEND_SEQ = 1'b0
    } reg_idx_t;

    localparam int FLAG_FIN_BIT = 0;
    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_ACK_BIT = 4;

    localparam logic [7:0] REPLY_SYNACK = 8'h12;
    localparam logic [7:0] REPLY_ACKPSH = 8'h18;
    localparam logic [7:0] REPLY_FINACK = 8'h11;

    typedef enum logic [1:0] {
        PH_NONE        = 2'd0,
        PH_SYN_RCVD    = 2'd1,
        PH_ESTABLISHED = 2'd2,
        PH_LAST_ACK    = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_ALLOC,
        ST_EMIT2
    } state_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [7:0]  flag_bits;
        logic [15:0] ip_total_len;
        logic [3:0]  ip_hdr_words;
        logic [3:0]  tcp_hdr_words;
    } seg_t;

    typedef struct packed {
        logic [7:0]  reply_flags;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic [15:0] reply_payload_len;
        logic [2:0]  conn_slot;
        logic        last_reply;
    } reply_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } tuple_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] expect_recv_seq;
        logic [31:0] next_send_seq;
    } conn_t;

endpackage

>>> src/tcp_passive_echo_conn_engine.sv
// tcp passive echo connection engine: tuple scan, phase update and reply generation
//
//  channel   direction  handshake            payload
//  segment   in         start & !busy        seg (tpec_pkg::seg_t)
//  reply     out        strobe, one cycle    reply (tpec_pkg::reply_t)
//  config    in/out     apb psel/penable     pwdata/prdata, initial_send_seq at 0x0
//
//  a segment scans the tuple memory one slot per cycle, stopping at the first match,
//  so it reads at most CONNECTIONS slots (one read port per memory sets this)
//  a second reply (echo followed by fin+ack) comes from ST_EMIT2 in the cycle after the echo
//  reset clears the slot valid bits and the control state; memories need no clearing
//  results are never held off, each reply appears on strobe for one cycle
module tcp_passive_echo_conn_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tpec_pkg::seg_t                seg,
    output logic                          strobe,
    output tpec_pkg::reply_t              reply,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpec_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tpec_pkg::*;

    // memories
    tuple_t tuple_mem [CONNECTIONS];
    conn_t  conn_mem  [CONNECTIONS];
    tuple_t tuple_q;
    conn_t  conn_q;

    state_t              state_reg, state_next;
    logic [31:0]         iss_reg;
    logic [CONNECTIONS-1:0] valid_reg, valid_next;
    seg_t                seg_reg, seg_next;
    logic [15:0]         plen_reg, plen_next;
    logic [SLOT_W-1:0]   scan_reg, scan_next;
    logic                issue_reg, issue_next;
    logic [SLOT_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                free_fnd_reg, free_fnd_next;
    logic [SLOT_W-1:0]   free_slot_reg, free_slot_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    conn_t               cur_reg, cur_next;
    logic                strobe_reg, strobe_next;
    reply_t              reply_reg, reply_next;

    logic                tuple_we;
    logic                conn_we;
    logic [SLOT_W-1:0]   wr_slot;
    tuple_t              tuple_wd;
    conn_t               conn_wd;

    logic                cfg_wr;
    logic [17:0]         diff;
    tuple_t              seg_tuple;
    logic                hit;
    logic                entry_valid;
    logic                data_echo;
    logic                fin_seen;
    logic [31:0]         ack_data;
    logic [31:0]         ack_one;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (reg_idx_t'(paddr[PADDR_W-1]) == REG_INITIAL_SEND_SEQ);
    assign prdata = (reg_idx_t'(paddr[PADDR_W-1]) == REG_INITIAL_SEND_SEQ) ? iss_reg : 32'd0;

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign reply  = reply_reg;

    assign diff = {2'b00, seg.ip_total_len}
                - {12'd0, seg.ip_hdr_words, 2'b00}
                - {12'd0, seg.tcp_hdr_words, 2'b00};

    assign seg_tuple = '{src_addr: seg_reg.src_addr, dst_addr: seg_reg.dst_addr,
                         src_port: seg_reg.src_port, dst_port: seg_reg.dst_port};
    assign entry_valid = valid_reg[cmp_idx_reg];
    assign hit         = cmp_vld_reg && entry_valid && (tuple_q == seg_tuple);
    assign data_echo   = seg_reg.flag_bits[FLAG_ACK_BIT] && (plen_reg != 16'd0);
    assign fin_seen    = seg_reg.flag_bits[FLAG_FIN_BIT];
    assign ack_data    = seg_reg.seq_num + 32'(plen_reg);
    assign ack_one     = seg_reg.seq_num + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg <= ISS_RESET;
        end
        else if (cfg_wr)
        begin
            iss_reg <= pwdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tuple_we)
        begin
            tuple_mem[wr_slot] <= tuple_wd;
        end
        tuple_q <= tuple_mem[scan_reg];
    end

    always_ff @(posedge clk)
    begin
        if (conn_we)
        begin
            conn_mem[wr_slot] <= conn_wd;
        end
        conn_q <= conn_mem[scan_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            issue_reg    <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            free_fnd_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            issue_reg    <= issue_next;
            cmp_vld_reg  <= cmp_vld_next;
            free_fnd_reg <= free_fnd_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg       <= seg_next;
        plen_reg      <= plen_next;
        scan_reg      <= scan_next;
        cmp_idx_reg   <= cmp_idx_next;
        free_slot_reg <= free_slot_next;
        slot_reg      <= slot_next;
        cur_reg       <= cur_next;
        reply_reg     <= reply_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        seg_next       = seg_reg;
        plen_next      = plen_reg;
        scan_next      = scan_reg;
        issue_next     = issue_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = 1'b0;
        free_fnd_next  = free_fnd_reg;
        free_slot_next = free_slot_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        strobe_next    = 1'b0;
        reply_next     = reply_reg;
        tuple_we       = 1'b0;
        conn_we        = 1'b0;
        wr_slot        = slot_reg;
        tuple_wd       = seg_tuple;
        conn_wd        = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    seg_next      = seg;
                    plen_next     = diff[17] ? 16'd0 : diff[15:0];
                    scan_next     = '0;
                    issue_next    = 1'b1;
                    free_fnd_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // read issue stage
                if (issue_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg;
                    if (scan_reg == LAST_SLOT)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
                // compare stage
                if (hit)
                begin
                    slot_next    = cmp_idx_reg;
                    cur_next     = conn_q;
                    issue_next   = 1'b0;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_EXEC;
                end
                else if (cmp_vld_reg)
                begin
                    if (!entry_valid && !free_fnd_reg)
                    begin
                        free_fnd_next  = 1'b1;
                        free_slot_next = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_SLOT)
                    begin
                        slot_next = free_fnd_reg ? free_slot_reg : cmp_idx_reg;
                        if (seg_reg.flag_bits[FLAG_SYN_BIT] && (free_fnd_reg || !entry_valid))
                        begin
                            state_next = ST_ALLOC;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_ALLOC:
            begin
                tuple_we   = 1'b1;
                conn_we    = 1'b1;
                conn_wd    = '{phase: PH_SYN_RCVD, expect_recv_seq: ack_one,
                               next_send_seq: iss_reg + 32'd1};
                valid_next[slot_reg] = 1'b1;
                strobe_next = 1'b1;
                reply_next  = '{reply_flags: REPLY_SYNACK, reply_seq: iss_reg,
                                reply_ack: ack_one, reply_payload_len: 16'd0,
                                conn_slot: 3'(slot_reg), last_reply: 1'b1};
                state_next  = ST_IDLE;
            end

            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (cur_reg.phase)
                    PH_SYN_RCVD:
                    begin
                        if (seg_reg.flag_bits[FLAG_ACK_BIT] &&
                            (seg_reg.ack_num == cur_reg.next_send_seq))
                        begin
                            conn_we       = 1'b1;
                            conn_wd.phase = PH_ESTABLISHED;
                        end
                    end
                    PH_ESTABLISHED:
                    begin
                        conn_we = data_echo || fin_seen;
                        conn_wd.expect_recv_seq = fin_seen ? ack_one :
                                                  (data_echo ? ack_data : cur_reg.expect_recv_seq);
                        conn_wd.next_send_seq = cur_reg.next_send_seq
                                              + (data_echo ? 32'(plen_reg) : 32'd0)
                                              + 32'(fin_seen);
                        conn_wd.phase = fin_seen ? PH_LAST_ACK : cur_reg.phase;
                        if (data_echo)
                        begin
                            strobe_next = 1'b1;
                            reply_next  = '{reply_flags: REPLY_ACKPSH,
                                            reply_seq: cur_reg.next_send_seq,
                                            reply_ack: ack_data,
                                            reply_payload_len: plen_reg,
                                            conn_slot: 3'(slot_reg),
                                            last_reply: !fin_seen};
                            if (fin_seen)
                            begin
                                state_next = ST_EMIT2;
                            end
                        end
                        else if (fin_seen)
                        begin
                            strobe_next = 1'b1;
                            reply_next  = '{reply_flags: REPLY_FINACK,
                                            reply_seq: cur_reg.next_send_seq,
                                            reply_ack: ack_one,
                                            reply_payload_len: 16'd0,
                                            conn_slot: 3'(slot_reg),
                                            last_reply: 1'b1};
                        end
                    end
                    PH_LAST_ACK:
                    begin
                        valid_next[slot_reg] = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_EMIT2:
            begin
                // fin+ack follows the echo, sequence advanced past the echoed bytes
                strobe_next = 1'b1;
                reply_next  = '{reply_flags: REPLY_FINACK,
                                reply_seq: reply_reg.reply_seq + 32'(reply_reg.reply_payload_len),
                                reply_ack: ack_one,
                                reply_payload_len: 16'd0,
                                conn_slot: 3'(slot_reg),
                                last_reply: 1'b1};
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> tb/tcp_passive_echo_conn_engine_checker.sv
// connection table predictor and reply checker for the tcp passive echo connection engine
module tcp_passive_echo_conn_engine_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  tpec_pkg::seg_t                seg,
    input  logic                          strobe,
    input  tpec_pkg::reply_t              reply,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpec_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    input  logic [31:0]                   prdata,
    input  logic                          pready,
    output int                            mismatches,
    output int                            outstanding
);
    import tpec_pkg::*;

    localparam logic [PADDR_W-1:0] ISS_ADDR = PADDR_W'(4 * int'(REG_INITIAL_SEND_SEQ));

    logic [31:0] iss_now;
    logic        slot_used [CONNECTIONS];
    tuple_t      slot_peer [CONNECTIONS];
    phase_t      slot_phase [CONNECTIONS];
    logic [31:0] rcv_next [CONNECTIONS];
    logic [31:0] snd_next [CONNECTIONS];
    reply_t      pending_replies [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic reply_t shape_reply(input logic [7:0] flags, input logic [31:0] sq,
                                           input logic [31:0] ak, input logic [15:0] len,
                                           input int slot);
        reply_t r;
        r.reply_flags       = flags;
        r.reply_seq         = sq;
        r.reply_ack         = ak;
        r.reply_payload_len = len;
        r.conn_slot         = 3'(slot);
        r.last_reply        = 1'b0;
        return r;
    endfunction

    task automatic predict_replies(input seg_t s);
        tuple_t t;
        int     diff;
        logic [15:0] plen;
        int     hit;
        int     k;
        reply_t batch [$];
        t = {s.src_addr, s.dst_addr, s.src_port, s.dst_port};
        diff = int'(s.ip_total_len) - 4 * int'(s.ip_hdr_words) - 4 * int'(s.tcp_hdr_words);
        plen = (diff > 0) ? 16'(diff) : 16'd0;
        hit = -1;
        for (k = 0; k < CONNECTIONS; k++)
            if (hit < 0 && slot_used[k] && slot_peer[k] == t)
                hit = k;
        if (hit < 0) begin
            if (!s.flag_bits[FLAG_SYN_BIT])
                return;
            for (k = 0; k < CONNECTIONS; k++)
                if (hit < 0 && !slot_used[k])
                    hit = k;
            // table full
            if (hit < 0)
                return;
            slot_used[hit]  = 1'b1;
            slot_peer[hit]  = t;
            rcv_next[hit]   = s.seq_num + 32'd1;
            snd_next[hit]   = iss_now + 32'd1;
            slot_phase[hit] = PH_SYN_RCVD;
            batch.push_back(shape_reply(REPLY_SYNACK, iss_now, rcv_next[hit], 16'd0, hit));
        end else begin
            case (slot_phase[hit])
                PH_SYN_RCVD:
                    if (s.flag_bits[FLAG_ACK_BIT] && s.ack_num == snd_next[hit])
                        slot_phase[hit] = PH_ESTABLISHED;
                PH_ESTABLISHED:
                begin
                    if (s.flag_bits[FLAG_ACK_BIT] && plen != 16'd0) begin
                        rcv_next[hit] = s.seq_num + {16'd0, plen};
                        batch.push_back(shape_reply(REPLY_ACKPSH, snd_next[hit], rcv_next[hit],
                                                    plen, hit));
                        snd_next[hit] = snd_next[hit] + {16'd0, plen};
                    end
                    if (s.flag_bits[FLAG_FIN_BIT]) begin
                        rcv_next[hit] = s.seq_num + 32'd1;
                        batch.push_back(shape_reply(REPLY_FINACK, snd_next[hit], rcv_next[hit],
                                                    16'd0, hit));
                        snd_next[hit]   = snd_next[hit] + 32'd1;
                        slot_phase[hit] = PH_LAST_ACK;
                    end
                end
                PH_LAST_ACK:
                    slot_used[hit] = 1'b0;
                default:
                    ;
            endcase
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last_reply = 1'b1;
        foreach (batch[k])
            pending_replies.push_back(batch[k]);
    endtask

    always @(posedge clk)
    begin : watch
        reply_t want;
        int k;
        if (!rst_n) begin
            mismatches = 0;
            iss_now    = ISS_RESET;
            for (k = 0; k < CONNECTIONS; k++)
                slot_used[k] = 1'b0;
            pending_replies.delete();
            outstanding <= 0;
        end else begin
            if (strobe) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("reply with none expected", reply.reply_seq, '0);
                end else begin
                    want = pending_replies.pop_front();
                    if (reply.reply_flags !== want.reply_flags)
                        report_mismatch("reply_flags", 32'(reply.reply_flags),
                                        32'(want.reply_flags));
                    if (reply.reply_seq !== want.reply_seq)
                        report_mismatch("reply_seq", reply.reply_seq, want.reply_seq);
                    if (reply.reply_ack !== want.reply_ack)
                        report_mismatch("reply_ack", reply.reply_ack, want.reply_ack);
                    if (reply.reply_payload_len !== want.reply_payload_len)
                        report_mismatch("reply_payload_len", 32'(reply.reply_payload_len),
                                        32'(want.reply_payload_len));
                    if (reply.conn_slot !== want.conn_slot)
                        report_mismatch("conn_slot", 32'(reply.conn_slot),
                                        32'(want.conn_slot));
                    if (reply.last_reply !== want.last_reply)
                        report_mismatch("last_reply", 32'(reply.last_reply),
                                        32'(want.last_reply));
                end
            end
            if (psel && penable && pready && paddr == ISS_ADDR) begin
                if (pwrite)
                    iss_now = pwdata;
                else if (prdata !== iss_now)
                    report_mismatch("initial_send_seq readback", prdata, iss_now);
            end
            if (start && !busy)
                predict_replies(seg);
            outstanding <= pending_replies.size();
        end
    end

endmodule

>>> tb/tcp_passive_echo_conn_engine_test.sv
// stimulus, watchdog and verdict for the tcp passive echo connection engine
module tcp_passive_echo_conn_engine_test;
    import tpec_pkg::*;

    localparam int FLOWS       = 12;
    localparam int CHUNK       = 124;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = CONNECTIONS + 8;
    localparam logic [PADDR_W-1:0] ISS_ADDR = PADDR_W'(4 * int'(REG_INITIAL_SEND_SEQ));
    localparam logic [7:0] F_FIN = 8'd1 << FLAG_FIN_BIT;
    localparam logic [7:0] F_SYN = 8'd1 << FLAG_SYN_BIT;
    localparam logic [7:0] F_ACK = 8'd1 << FLAG_ACK_BIT;
    localparam logic [7:0] F_PSH = 8'h08;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    seg_t               seg     = '0;
    logic               strobe;
    reply_t             reply;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 mismatches;
    int                 outstanding;

    int          quiet_cycles = 0;
    bit          sender_idles = 1'b1;
    logic [31:0] cur_iss      = ISS_RESET;
    tuple_t      flow_tuple [FLOWS];
    int          flow_stage [FLOWS];
    logic [31:0] flow_iss [FLOWS];
    logic [31:0] flow_seq [FLOWS];

    tcp_passive_echo_conn_engine dut (.*);
    tcp_passive_echo_conn_engine_checker watcher (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic seg_t build_seg(input tuple_t t, input logic [31:0] sq,
                                       input logic [31:0] ak, input logic [7:0] fl,
                                       input logic [15:0] total, input logic [3:0] ihl,
                                       input logic [3:0] thl);
        seg_t s;
        s.src_addr      = t.src_addr;
        s.dst_addr      = t.dst_addr;
        s.src_port      = t.src_port;
        s.dst_port      = t.dst_port;
        s.seq_num       = sq;
        s.ack_num       = ak;
        s.flag_bits     = fl;
        s.ip_total_len  = total;
        s.ip_hdr_words  = ihl;
        s.tcp_hdr_words = thl;
        return s;
    endfunction

    // well-formed next step of a flow, random content
    task automatic next_flow_segment(input int f, output seg_t s);
        logic [3:0]  ihl;
        logic [3:0]  thl;
        logic [15:0] plen;
        logic [15:0] total;
        logic [7:0]  fl;
        logic [31:0] ak;
        int          roll;
        ihl  = 4'($urandom_range(15, 5));
        thl  = 4'($urandom_range(15, 5));
        roll = $urandom_range(99);
        plen = 16'd0;
        ak   = $urandom;
        fl   = 8'($urandom);
        case (flow_stage[f])
            0:
            begin
                fl = F_SYN | (8'($urandom) & 8'hFC);
                flow_iss[f] = cur_iss;
                flow_seq[f] = $urandom;
            end
            1:
            begin
                fl   = F_ACK | (8'($urandom) & 8'hE8);
                plen = 16'($urandom_range(20));
                if (roll < 90)
                    ak = flow_iss[f] + 32'd1;
            end
            2:
            begin
                if (roll < 75) begin
                    fl = F_ACK | F_PSH | (8'($urandom) & 8'hE4);
                    if (roll < 65)
                        plen = ($urandom_range(19) == 0) ? 16'($urandom_range(65000, 1))
                                                         : 16'($urandom_range(1460, 1));
                end else if (roll < 88) begin
                    fl   = F_ACK | F_FIN | (8'($urandom) & 8'hE4);
                    plen = 16'($urandom_range(1460));
                end else begin
                    fl   = F_FIN | (8'($urandom) & 8'hE4);
                    plen = 16'($urandom_range(100));
                end
            end
            default:
                ;
        endcase
        total = 16'(4 * (int'(ihl) + int'(thl)) + int'(plen));
        s = build_seg(flow_tuple[f], flow_seq[f], ak, fl, total, ihl, thl);
        case (flow_stage[f])
            0:
            begin
                flow_seq[f]   = flow_seq[f] + 32'd1;
                flow_stage[f] = 1;
            end
            1:
                if (ak == flow_iss[f] + 32'd1)
                    flow_stage[f] = 2;
            2:
            begin
                if (fl[FLAG_ACK_BIT])
                    flow_seq[f] = flow_seq[f] + {16'd0, plen};
                if (fl[FLAG_FIN_BIT]) begin
                    flow_seq[f]   = flow_seq[f] + 32'd1;
                    flow_stage[f] = 3;
                end
            end
            default:
                flow_stage[f] = 0;
        endcase
    endtask

    function automatic seg_t noise_segment();
        seg_t s;
        s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(1) == 1)
            {s.src_addr, s.dst_addr, s.src_port, s.dst_port} =
                flow_tuple[$urandom_range(FLOWS - 1)];
        return s;
    endfunction

    task automatic send(input seg_t s);
        while (sender_idles && $urandom_range(99) < 29) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        seg   <= s;
        do @(posedge clk); while (busy);
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ISS_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic retune(input logic [31:0] value);
        settle();
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
        cur_iss = value;
    endtask

    initial
    begin
        seg_t s;
        int   f;
        int   chunk;
        int   flow_items;
        for (f = 0; f < FLOWS; f++) begin
            flow_tuple[f] = {$urandom, $urandom, 16'($urandom), 16'($urandom)};
            flow_stage[f] = 0;
            flow_iss[f]   = ISS_RESET;
            flow_seq[f]   = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, '0);

        // unmatched non-syn, then a full lifecycle on one tuple
        send(build_seg(flow_tuple[0], $urandom, $urandom, F_ACK, 16'd40, 4'd5, 4'd5));
        send(build_seg(flow_tuple[0], 32'hFFFF_FFFF, '0, F_SYN, 16'd0, 4'd0, 4'd0));
        send(build_seg(flow_tuple[0], '0, '0, F_SYN, 16'd40, 4'd5, 4'd5));
        send(build_seg(flow_tuple[0], '0, ISS_RESET, F_ACK, 16'd40, 4'd5, 4'd5));
        send(build_seg(flow_tuple[0], '0, ISS_RESET + 32'd1, F_ACK, 16'd40, 4'd5, 4'd5));
        send(build_seg(flow_tuple[0], '0, $urandom, F_ACK, 16'd40, 4'd5, 4'd5));
        send(build_seg(flow_tuple[0], '0, $urandom, F_ACK | F_PSH, 16'd10, 4'hF, 4'hF));
        send(build_seg(flow_tuple[0], 32'hFFFF_FFF0, '0, F_ACK | F_PSH, 16'hFFFF, 4'd0, 4'd0));
        send(build_seg(flow_tuple[0], 32'h0000_1234, '0, F_ACK | F_PSH | F_FIN, 16'd140,
                       4'd5, 4'd5));
        send(build_seg(flow_tuple[0], $urandom, $urandom, 8'hFF, 16'hFFFF, 4'hF, 4'hF));

        // fill the table, then one syn too many
        for (f = 1; f <= CONNECTIONS + 1; f++) begin
            next_flow_segment(f, s);
            send(s);
        end
        send(build_seg(flow_tuple[1], flow_seq[1], $urandom, F_FIN, 16'd40, 4'd5, 4'd5));

        for (chunk = 0; chunk < 5; chunk++) begin
            case (chunk)
                1: retune(32'hFFFF_FFFF);
                2: retune(32'h0000_0000);
                3: retune($urandom);
                4: retune(32'h8000_0000);
                default: ;
            endcase
            sender_idles = (chunk != 2);
            flow_items = 0;
            while (flow_items < CHUNK) begin
                if ($urandom_range(99) < 15) begin
                    send(noise_segment());
                end else begin
                    next_flow_segment($urandom_range(FLOWS - 1), s);
                    send(s);
                    flow_items++;
                end
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
